// File: rtl/core/ordered_array_list_engine_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ordered array list engine
// Implication checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define OALE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oale: check failed");
// next-cycle implication
`define OALE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oale: check failed");
`else
`define OALE_ASSERT_IMPL(label, ante, cons)
`define OALE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/oale_pkg.sv
// ---------------------------------------------------------------------------
// oale_pkg
// Field widths, opcodes, status codes and cell actions of the list engine.
// ---------------------------------------------------------------------------
package oale_pkg;

  localparam int OPC_W  = 2;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 7;
  localparam int LEN_W  = 8;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // what a cell loads on the next edge
  typedef enum logic [1:0] {
    ACT_HOLD       = 2'd0,
    ACT_LOAD_NEW   = 2'd1,
    ACT_TAKE_LEFT  = 2'd2,
    ACT_TAKE_RIGHT = 2'd3
  } cell_act_t;

endpackage

// File: rtl/core/oale_if.sv
// ---------------------------------------------------------------------------
// oale_in_if / oale_out_if
// Valid/ready channels carrying requests and results of the list engine.
// ---------------------------------------------------------------------------
interface oale_in_if;
  logic                              valid;
  logic                              ready;
  logic [oale_pkg::OPC_W-1:0]        opcode;
  logic [oale_pkg::POS_W-1:0]        position;
  logic signed [oale_pkg::VAL_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

interface oale_out_if;
  logic                              valid;
  logic                              ready;
  logic [oale_pkg::STAT_W-1:0]       status;
  logic [oale_pkg::FIDX_W-1:0]       found_index;
  logic signed [oale_pkg::VAL_W-1:0] read_value;
  logic [oale_pkg::LEN_W-1:0]        list_length;

  modport source (output valid, output status, output found_index, output read_value,
                  output list_length, input ready);
  modport sink   (input valid, input status, input found_index, input read_value,
                  input list_length, output ready);
endinterface

// File: rtl/core/oale_cell.sv
// ---------------------------------------------------------------------------
// oale_cell
// One list slot: holds a word, shifts to/from its neighbors, compares.
// ---------------------------------------------------------------------------
module oale_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  oale_pkg::cell_act_t    act,
  input  logic [DATA_WIDTH-1:0]  left_data,
  input  logic [DATA_WIDTH-1:0]  right_data,
  input  logic [DATA_WIDTH-1:0]  new_data,
  input  logic [DATA_WIDTH-1:0]  cmp_data,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic                   match_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    unique case (act)
      oale_pkg::ACT_HOLD:       data_nxt = data_r;
      oale_pkg::ACT_LOAD_NEW:   data_nxt = new_data;
      oale_pkg::ACT_TAKE_LEFT:  data_nxt = left_data;
      oale_pkg::ACT_TAKE_RIGHT: data_nxt = right_data;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign match_o = (data_r == cmp_data);

endmodule

// File: rtl/core/ordered_array_list_engine.sv
// ---------------------------------------------------------------------------
// ordered_array_list_engine
// Array list with insert-with-shift, remove-first-match and indexed read.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request item: opcode, position, item_value.
//   out_ch returns exactly one result item per request: status,
//   found_index, read_value and list_length after the operation.
//   Storage is a row of CAPACITY cells; each cell shifts from a neighbor,
//   so insert and remove move the whole tail at once.
// Steps, one item at a time (a new item waits until the result is pushed):
//   insert, read, unused opcode: S_EXEC, then S_DONE pushes the result.
//   remove: S_EXEC, then S_SCAN from index 0 up to the first match or the
//   list end, then S_DONE; the search walks one cell per cycle.
//   A finished result waits in the output register while the next item is
//   accepted; a stalled out_ch holds the block once the next result is ready.
// Reset: list length goes to zero and out_ch goes idle. Cell contents are
//   not cleared; only slots below the length are ever read.
// ---------------------------------------------------------------------------
`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  oale_in_if.sink       in_ch,
  oale_out_if.source    out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);     // count width
  localparam int IW   = $clog2(CAPACITY);         // cell index width
  localparam int CMPW = (CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                scan_r, scan_nxt;
  logic [oale_pkg::OPC_W-1:0]   op_r;
  logic [CMPW-1:0]              pos_r;
  logic [DATA_WIDTH-1:0]        word_r;

  oale_pkg::status_t            res_status_r, res_status_nxt;
  logic [oale_pkg::FIDX_W-1:0]  res_found_r, res_found_nxt;
  logic [oale_pkg::VAL_W-1:0]   res_rval_r, res_rval_nxt;

  logic                         out_valid_r, out_valid_nxt;
  oale_pkg::status_t            out_status_r;
  logic [oale_pkg::FIDX_W-1:0]  out_found_r;
  logic [oale_pkg::VAL_W-1:0]   out_rval_r;
  logic [oale_pkg::LEN_W-1:0]   out_len_r;

  logic                         out_free;
  logic                         in_fire;
  logic                         push;
  logic                         ins_ok;
  logic                         rd_ok;
  logic                         scan_end;
  logic                         scan_hit;
  logic [DATA_WIDTH-1:0]        rd_word;

  logic [DATA_WIDTH-1:0]        ent [CAPACITY];
  logic [CAPACITY-1:0]          match;
  oale_pkg::cell_act_t          act [CAPACITY];

  // ---- handshake ----
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_DONE) && out_free);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = (state_r == S_DONE) && out_free;

  // ---- decisions on the cell row ----
  assign ins_ok   = (count_r < CW'(CAPACITY)) && (pos_r <= CMPW'(count_r));
  assign rd_ok    = pos_r < CMPW'(count_r);
  assign rd_word  = ent[pos_r[IW-1:0]];
  assign scan_end = (scan_r == count_r);
  assign scan_hit = (state_r == S_SCAN) && !scan_end && match[scan_r[IW-1:0]];

  // ---- cell row ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = ent[i];
    end else begin : g_mid_l
      assign left_d = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = ent[i];
    end else begin : g_mid_r
      assign right_d = ent[i+1];
    end

    always_comb begin
      act[i] = oale_pkg::ACT_HOLD;
      if ((state_r == S_EXEC) && (op_r == oale_pkg::OP_INSERT) && ins_ok) begin
        if (CMPW'(i) == pos_r) begin
          act[i] = oale_pkg::ACT_LOAD_NEW;
        end else if (CMPW'(i) > pos_r) begin
          act[i] = oale_pkg::ACT_TAKE_LEFT;
        end
      end else if (scan_hit && (CW'(i) >= scan_r)) begin
        act[i] = oale_pkg::ACT_TAKE_RIGHT;
      end
    end

    oale_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .act        (act[i]),
      .left_data  (left_d),
      .right_data (right_d),
      .new_data   (word_r),
      .cmp_data   (word_r),
      .data_o     (ent[i]),
      .match_o    (match[i])
    );
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_rval_nxt   = res_rval_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = oale_pkg::ST_OK;
        res_found_nxt  = '0;
        res_rval_nxt   = '0;
        state_nxt      = S_DONE;
        unique case (op_r)
          oale_pkg::OP_INSERT: begin
            if (count_r >= CW'(CAPACITY)) begin
              res_status_nxt = oale_pkg::ST_FULL;
            end else if (!ins_ok) begin
              res_status_nxt = oale_pkg::ST_RANGE;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
          oale_pkg::OP_REMOVE: begin
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
          oale_pkg::OP_READ: begin
            if (rd_ok) begin
              res_rval_nxt = oale_pkg::VAL_W'($signed(rd_word));
            end else begin
              res_status_nxt = oale_pkg::ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (scan_end) begin
          res_status_nxt = oale_pkg::ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else if (scan_hit) begin
          res_found_nxt = oale_pkg::FIDX_W'(scan_r);
          count_nxt     = count_r - 1'b1;
          state_nxt     = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DONE: begin
        if (push) begin
          state_nxt = in_fire ? S_EXEC : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_rval_r   <= res_rval_nxt;
    if (in_fire) begin
      op_r   <= in_ch.opcode;
      pos_r  <= CMPW'(in_ch.position);
      word_r <= DATA_WIDTH'(in_ch.item_value);
    end
    if (push) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_rval_r   <= res_rval_r;
      out_len_r    <= oale_pkg::LEN_W'(count_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.read_value  = out_rval_r;
  assign out_ch.list_length = out_len_r;

  // ---- checks ----
  `OALE_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `OALE_ASSERT_NEXT(a_accept_exec, in_fire, state_r == S_EXEC)
  `OALE_ASSERT_NEXT(a_count_quiet, (state_r == S_IDLE) || (state_r == S_DONE), $stable(count_r))
  `OALE_ASSERT_NEXT(a_push_valid, push, out_valid_r)
  `OALE_ASSERT_IMPL(a_hit_in_range, scan_hit, scan_r < count_r)

endmodule
